// File: hw/rtl/mfr_pkg.sv
package mfr_pkg;

	localparam int unsigned ByteW = 8;
	localparam int unsigned SyncW = 16;
	localparam int unsigned SizeW = 32;
	localparam int unsigned KindW = 3;
	localparam int unsigned DataW = 32;
	localparam int unsigned AddrW = 3;

	localparam logic [0:0] RegSyncPattern = 1'b0;

	typedef enum logic [2:0] {
		PH_SYNC0 = 3'd0,
		PH_SYNC1 = 3'd1,
		PH_SIZE  = 3'd2,
		PH_CODE  = 3'd3,
		PH_DATA  = 3'd4,
		PH_CSUM  = 3'd5
	} phase_t;

	typedef enum logic [KindW-1:0] {
		KIND_PAYLOAD  = 3'd0,
		KIND_GOOD     = 3'd1,
		KIND_BADSUM   = 3'd2,
		KIND_SYNCERR  = 3'd3,
		KIND_ZEROSIZE = 3'd4
	} kind_t;

	typedef struct packed {
		logic              valid;
		kind_t             kind;
		logic [ByteW-1:0]  payload;
		logic [ByteW-1:0]  code;
	} result_t;

endpackage

// File: hw/rtl/mfr_cfg.sv
module mfr_cfg import mfr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [AddrW-1:0] paddr,
	input  logic [DataW-1:0] pwdata,
	output logic [DataW-1:0] prdata,
	output logic             pready,
	output logic [SyncW-1:0] sync_pattern
);

	logic [SyncW-1:0] sync_q;
	logic             wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready & (paddr[2] == RegSyncPattern);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q <= '0;
		end else if (wr_en) begin
			sync_q <= pwdata[SyncW-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == RegSyncPattern) begin
			prdata = {{(DataW-SyncW){1'b0}}, sync_q};
		end
	end

	assign sync_pattern = sync_q;

endmodule

// File: hw/rtl/mfr_deframer.sv
module mfr_deframer import mfr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  logic [ByteW-1:0] rx_byte,
	input  logic [SyncW-1:0] sync_pattern,
	output result_t          res
);

	phase_t           phase_q, phase_d;
	logic [1:0]       hdr_cnt_q, hdr_cnt_d;
	logic [ByteW-1:0] first_sync_q, first_sync_d;
	logic [SizeW-1:0] size_q, size_d;
	logic [SizeW-1:0] left_q, left_d;
	logic [ByteW-1:0] code_q, code_d;
	logic [ByteW-1:0] sum_q, sum_d;
	logic [SizeW-1:0] size_asm;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_SYNC0;
			hdr_cnt_q    <= '0;
			first_sync_q <= '0;
			size_q       <= '0;
			left_q       <= '0;
			code_q       <= '0;
			sum_q        <= '0;
		end else if (advance) begin
			phase_q      <= phase_d;
			hdr_cnt_q    <= hdr_cnt_d;
			first_sync_q <= first_sync_d;
			size_q       <= size_d;
			left_q       <= left_d;
			code_q       <= code_d;
			sum_q        <= sum_d;
		end
	end

	always_comb begin
		size_asm = size_q;
		case (hdr_cnt_q)
			2'd0: size_asm[7:0]   = size_q[7:0]   | rx_byte;
			2'd1: size_asm[15:8]  = size_q[15:8]  | rx_byte;
			2'd2: size_asm[23:16] = size_q[23:16] | rx_byte;
			default: size_asm[31:24] = size_q[31:24] | rx_byte;
		endcase
	end

	always_comb begin
		phase_d      = phase_q;
		hdr_cnt_d    = hdr_cnt_q;
		first_sync_d = first_sync_q;
		size_d       = size_q;
		left_d       = left_q;
		code_d       = code_q;
		sum_d        = sum_q;
		res          = '{valid: 1'b0, kind: KIND_PAYLOAD, payload: '0, code: '0};
		case (phase_q)
			PH_SYNC1: begin
				if ({rx_byte, first_sync_q} != sync_pattern) begin
					phase_d   = PH_SYNC0;
					res.valid = 1'b1;
					res.kind  = KIND_SYNCERR;
				end else begin
					hdr_cnt_d = '0;
					size_d    = '0;
					phase_d   = PH_SIZE;
				end
			end
			PH_SIZE: begin
				size_d = size_asm;
				if (hdr_cnt_q != 2'd3) begin
					hdr_cnt_d = hdr_cnt_q + 2'd1;
				end else begin
					hdr_cnt_d = '0;
					if (size_asm == '0) begin
						phase_d   = PH_SYNC0;
						res.valid = 1'b1;
						res.kind  = KIND_ZEROSIZE;
					end else begin
						left_d  = size_asm - SizeW'(1);
						phase_d = PH_CODE;
					end
				end
			end
			PH_CODE: begin
				code_d  = rx_byte;
				sum_d   = rx_byte;
				phase_d = (left_q != '0) ? PH_DATA : PH_CSUM;
			end
			PH_DATA: begin
				sum_d       = sum_q + rx_byte;
				left_d      = left_q - SizeW'(1);
				if (left_q == SizeW'(1)) begin
					phase_d = PH_CSUM;
				end
				res.valid   = 1'b1;
				res.kind    = KIND_PAYLOAD;
				res.payload = rx_byte;
				res.code    = code_q;
			end
			PH_CSUM: begin
				phase_d   = PH_SYNC0;
				res.valid = 1'b1;
				res.kind  = (rx_byte == sum_q) ? KIND_GOOD : KIND_BADSUM;
				res.code  = code_q;
			end
			default: begin
				first_sync_d = rx_byte;
				phase_d      = PH_SYNC1;
			end
		endcase
	end

endmodule

// File: hw/rtl/message_frame_receiver.sv
// A byte is held in the input register and its result in the result register.
// Throughput: one byte per cycle; the input register and the result register each
// advance whenever the stage after them is empty or drains in the same cycle.
// Reset: arst_n clears the deframer to the hunt for the first sync byte, empties
// both registers and sets the sync pattern to zero.
module message_frame_receiver import mfr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [AddrW-1:0] paddr,
	input  logic [DataW-1:0] pwdata,
	output logic [DataW-1:0] prdata,
	output logic             pready,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [7:0]       s_tdata,  // [7:0] rx_byte
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [15:0]      m_tdata,  // [7:0] payload_byte, [15:8] message_code
	output logic [2:0]       m_tuser   // [2:0] result_kind
);

	logic [SyncW-1:0] sync_pattern;
	logic             valid_s1;
	logic [ByteW-1:0] byte_s1;
	logic             advance;
	result_t          res;
	logic             valid_s2;
	kind_t            kind_s2;
	logic [ByteW-1:0] payload_s2;
	logic [ByteW-1:0] code_s2;

	mfr_cfg u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.sync_pattern (sync_pattern)
	);

	assign advance  = valid_s1 & (~valid_s2 | m_tready);
	assign s_tready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready & s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	mfr_deframer u_deframer (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.rx_byte      (byte_s1),
		.sync_pattern (sync_pattern),
		.res          (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (~valid_s2 | m_tready) begin
			valid_s2 <= advance & res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance & res.valid) begin
			kind_s2    <= res.kind;
			payload_s2 <= res.payload;
			code_s2    <= res.code;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {code_s2, payload_s2};
	assign m_tuser  = kind_s2;

endmodule

// File: verif/frame_result_checker.sv
`timescale 1ns / 1ps

module frame_result_checker import mfr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [AddrW-1:0] paddr,
	input  logic [DataW-1:0] pwdata,
	input  logic             pready,
	input  logic             s_tvalid,
	input  logic             s_tready,
	input  logic [7:0]       s_tdata,  // [7:0] rx_byte
	input  logic             m_tvalid,
	input  logic             m_tready,
	input  logic [15:0]      m_tdata,  // [7:0] payload_byte, [15:8] message_code
	input  logic [2:0]       m_tuser,  // [2:0] result_kind
	output int               fail_count,
	output int               pending,
	output int               results_seen,
	output int               good_frames,
	output int               bad_sums,
	output int               sync_errors,
	output int               zero_sizes
);

	localparam logic [AddrW-1:0] SyncAddr = AddrW'({RegSyncPattern, 2'b00});

	typedef struct packed {
		kind_t      kind;
		logic [7:0] payload;
		logic [7:0] code;
	} deframe_result_t;

	logic [15:0]     sync_exp;
	phase_t          phase;
	logic [1:0]      size_idx;
	logic [7:0]      sync_lo;
	logic [31:0]     size_acc;
	logic [31:0]     remaining;
	logic [7:0]      msg_id;
	logic [7:0]      csum;
	deframe_result_t want_q[$];

	task automatic deframe_byte(input logic [7:0] b);
		deframe_result_t r;
		bit              hit;
		r   = '0;
		hit = 1'b0;
		case (phase)
			PH_SYNC1: begin
				if ({b, sync_lo} != sync_exp) begin
					phase  = PH_SYNC0;
					r.kind = KIND_SYNCERR;
					hit    = 1'b1;
				end else begin
					size_idx = '0;
					size_acc = '0;
					phase    = PH_SIZE;
				end
			end
			PH_SIZE: begin
				size_acc = size_acc | (32'(b) << (8 * size_idx));
				if (size_idx != 2'd3) begin
					size_idx = size_idx + 2'd1;
				end else begin
					size_idx = '0;
					if (size_acc == '0) begin
						phase  = PH_SYNC0;
						r.kind = KIND_ZEROSIZE;
						hit    = 1'b1;
					end else begin
						remaining = size_acc - 32'd1;
						phase     = PH_CODE;
					end
				end
			end
			PH_CODE: begin
				msg_id = b;
				csum   = b;
				phase  = (remaining != '0) ? PH_DATA : PH_CSUM;
			end
			PH_DATA: begin
				csum      = csum + b;
				remaining = remaining - 32'd1;
				if (remaining == '0) begin
					phase = PH_CSUM;
				end
				r.kind    = KIND_PAYLOAD;
				r.payload = b;
				r.code    = msg_id;
				hit       = 1'b1;
			end
			PH_CSUM: begin
				phase  = PH_SYNC0;
				r.kind = (b == csum) ? KIND_GOOD : KIND_BADSUM;
				r.code = msg_id;
				hit    = 1'b1;
			end
			default: begin
				sync_lo = b;
				phase   = PH_SYNC1;
			end
		endcase
		if (hit) begin
			want_q.push_back(r);
		end
	endtask

	task automatic compare_result();
		deframe_result_t want;
		if (want_q.size() == 0) begin
			$error("unexpected result: kind %0d, payload %0h, code %0h",
				m_tuser, m_tdata[7:0], m_tdata[15:8]);
			fail_count++;
		end else begin
			want = want_q.pop_front();
			results_seen++;
			case (want.kind)
				KIND_GOOD:     good_frames++;
				KIND_BADSUM:   bad_sums++;
				KIND_SYNCERR:  sync_errors++;
				KIND_ZEROSIZE: zero_sizes++;
				default:       ;
			endcase
			if (m_tuser != want.kind) begin
				$error("result_kind: expected %0d, actual %0d", want.kind, m_tuser);
				fail_count++;
			end
			if (m_tdata[7:0] != want.payload) begin
				$error("payload_byte: expected %0h, actual %0h", want.payload, m_tdata[7:0]);
				fail_count++;
			end
			if (m_tdata[15:8] != want.code) begin
				$error("message_code: expected %0h, actual %0h", want.code, m_tdata[15:8]);
				fail_count++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_exp     = '0;
			phase        = PH_SYNC0;
			size_idx     = '0;
			sync_lo      = '0;
			size_acc     = '0;
			remaining    = '0;
			msg_id       = '0;
			csum         = '0;
			want_q.delete();
			fail_count   = 0;
			results_seen = 0;
			good_frames  = 0;
			bad_sums     = 0;
			sync_errors  = 0;
			zero_sizes   = 0;
			pending     <= 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == SyncAddr) begin
				sync_exp = pwdata[15:0];
			end
			if (m_tvalid && m_tready) begin
				compare_result();
			end
			if (s_tvalid && s_tready) begin
				deframe_byte(s_tdata);
			end
			pending <= want_q.size();
		end
	end

endmodule

// File: verif/tb_message_frame_receiver.sv
`timescale 1ns / 1ps

module tb_message_frame_receiver;
	import mfr_pkg::*;

	localparam logic [AddrW-1:0] SyncAddr     = AddrW'({RegSyncPattern, 2'b00});
	localparam logic [AddrW-1:0] UnmappedAddr = SyncAddr + AddrW'(4);
	localparam int               CycleLimit   = 1000000;
	localparam int               PhaseBytes   = 300;

	logic             clk;
	logic             arst_n;
	logic             psel;
	logic             penable;
	logic             pwrite;
	logic [AddrW-1:0] paddr;
	logic [DataW-1:0] pwdata;
	logic [DataW-1:0] prdata;
	logic             pready;
	logic             s_tvalid;
	logic             s_tready;
	logic [7:0]       s_tdata;   // [7:0] rx_byte
	logic             m_tvalid;
	logic             m_tready;
	logic [15:0]      m_tdata;   // [7:0] payload_byte, [15:8] message_code
	logic [2:0]       m_tuser;   // [2:0] result_kind

	int          fail_count;
	int          pending;
	int          results_seen;
	int          good_frames;
	int          bad_sums;
	int          sync_errors;
	int          zero_sizes;
	int          src_idle_pct;
	int          sink_idle_pct;
	int          bytes_sent;
	logic [15:0] cur_sync;
	logic [7:0]  frame_q[$];

	message_frame_receiver u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	frame_result_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.pready       (pready),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser),
		.fail_count   (fail_count),
		.pending      (pending),
		.results_seen (results_seen),
		.good_frames  (good_frames),
		.bad_sums     (bad_sums),
		.sync_errors  (sync_errors),
		.zero_sizes   (zero_sizes)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (CycleLimit) @(posedge clk);
		$display("CHECKS FAILED");
		$finish;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= sink_idle_pct);
		end
	end

	task automatic push_byte(input logic [7:0] b);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
		bytes_sent++;
	endtask

	task automatic send_frame_q();
		while (frame_q.size() != 0) begin
			push_byte(frame_q.pop_front());
		end
	endtask

	task automatic build_frame(input logic [15:0] sync, input logic [31:0] size,
		input logic [7:0] id, input bit corrupt);
		logic [7:0] sum;
		logic [7:0] p;
		frame_q = {};
		frame_q.push_back(sync[7:0]);
		frame_q.push_back(sync[15:8]);
		for (int i = 0; i < 4; i++) begin
			frame_q.push_back(size[8*i +: 8]);
		end
		if (size != '0) begin
			frame_q.push_back(id);
			sum = id;
			for (longint unsigned i = 1; i < size; i++) begin
				p = 8'($urandom);
				sum = sum + p;
				frame_q.push_back(p);
			end
			frame_q.push_back(corrupt ? 8'(sum + $urandom_range(1, 255)) : sum);
		end
	endtask

	task automatic write_reg(input logic [AddrW-1:0] addr, input logic [DataW-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// wait out every expected transfer, then the pipeline
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic set_sync(input logic [15:0] value);
		write_reg(SyncAddr, DataW'(value));
		cur_sync = value;
	endtask

	function automatic logic [31:0] pick_size();
		int r;
		r = $urandom_range(99);
		if (r < 80) return $urandom_range(1, 8);
		if (r < 95) return $urandom_range(9, 40);
		return $urandom_range(41, 300);
	endfunction

	// mostly well-formed frames, with bad checksums, broken sync and zero sizes mixed in
	task automatic run_link_traffic(input int n_bytes);
		int         stop_at;
		int         r;
		int         pairs;
		logic [7:0] lo;
		logic [7:0] hi;
		stop_at = bytes_sent + n_bytes;
		while (bytes_sent < stop_at) begin
			r = $urandom_range(99);
			if (r < 72) begin
				build_frame(cur_sync, pick_size(), 8'($urandom), $urandom_range(9) == 0);
				send_frame_q();
			end else if (r < 82) begin
				build_frame(cur_sync, '0, '0, 1'b0);
				send_frame_q();
			end else begin
				pairs = $urandom_range(1, 3);
				repeat (pairs) begin
					lo = ($urandom_range(2) == 0) ? cur_sync[7:0] : 8'($urandom);
					hi = 8'($urandom);
					if ({hi, lo} == cur_sync) hi = hi ^ 8'h01;
					push_byte(lo);
					push_byte(hi);
				end
			end
		end
	endtask

	initial begin
		logic [15:0] next_sync;
		logic [31:0] huge_size;
		src_idle_pct  = 0;
		sink_idle_pct = 0;
		bytes_sent    = 0;
		cur_sync      = '0;
		arst_n   <= 1'b0;
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		paddr    <= '0;
		pwdata   <= '0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset pattern: frame with no payload, zero size, sync mismatch on the high byte
		build_frame(cur_sync, 32'd1, 8'hFF, 1'b0);
		send_frame_q();
		build_frame(cur_sync, '0, '0, 1'b0);
		send_frame_q();
		push_byte(8'h00);
		push_byte(8'h01);
		drain();
		set_sync(16'hFFFF);
		build_frame(cur_sync, 32'd2, 8'h00, 1'b1);
		send_frame_q();

		drain();
		set_sync(16'($urandom));
		src_idle_pct  = 37;
		sink_idle_pct = 86;
		run_link_traffic(PhaseBytes);

		drain();
		write_reg(UnmappedAddr, $urandom);
		set_sync(16'($urandom));
		src_idle_pct  = 86;
		sink_idle_pct = 37;
		run_link_traffic(PhaseBytes);

		// change the pattern between the two sync bytes
		drain();
		src_idle_pct  = 0;
		sink_idle_pct = 0;
		next_sync = 16'($urandom);
		build_frame(next_sync, 32'd3, 8'($urandom), 1'b0);
		push_byte(frame_q.pop_front());
		drain();
		set_sync(next_sync);
		send_frame_q();
		run_link_traffic(PhaseBytes);

		// size with the top byte set: only the start of it can be sent
		huge_size = {1'b1, 31'($urandom)};
		build_frame(cur_sync, 32'd1, 8'($urandom), 1'b0);
		void'(frame_q.pop_back());
		for (int i = 0; i < 4; i++) begin
			frame_q[2 + i] = huge_size[8*i +: 8];
		end
		repeat (20) frame_q.push_back(8'($urandom));
		send_frame_q();
		drain();

		$display("Sent %0d link bytes under five sync patterns, one changed between sync bytes.",
			bytes_sent);
		$display("Compared %0d results: %0d good, %0d bad checksum, %0d sync error, %0d zero size.",
			results_seen, good_frames, bad_sums, sync_errors, zero_sizes);
		if (fail_count == 0 && pending == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// File: files.f
hw/rtl/mfr_pkg.sv
hw/rtl/mfr_cfg.sv
hw/rtl/mfr_deframer.sv
hw/rtl/message_frame_receiver.sv
verif/frame_result_checker.sv
verif/tb_message_frame_receiver.sv
